### rtl/amdfs_pkg.sv
// types and constants for the adjacency matrix depth-first walker
package amdfs_pkg;

  localparam int unsigned RowW      = 16;  // adjacency row bitmask width
  localparam int unsigned VtxW      = 4;   // vertex number width
  localparam int unsigned CntW      = 5;   // vertex count and stack depth width
  localparam int unsigned ResultCap = 16;  // most vertices one walk can emit

  // item kind codes
  localparam logic KindLoad  = 1'b0;
  localparam logic KindStart = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [VtxW-1:0] row_index;
    logic [RowW-1:0] row_bits;
    logic [VtxW-1:0] start_vertex;
  } amdfs_item_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
    logic            bad_start;
  } amdfs_result_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StPop
  } amdfs_state_e;

endpackage

### rtl/adjacency_matrix_dfs_order.sv
// depth-first preorder walker over an adjacency bit matrix held in memory
//
//   channel   ports                          transfer condition
//   item      start, busy, item_i            start high and busy low
//   result    strobe_o, result_o             strobe_o high (one cycle, no stall)
//   config    cfg_we_i, cfg_wdata_i          cfg_we_i high
//
// A load item or a bad start is taken while idle and the walker stays idle. A start item that
// reaches N vertices makes N + P scan steps with P = N - 1 pops: each scan step works on the
// registered adjacency row, and each pop adds a StPop state for the stack read.
// A vertex is registered out in the cycle after the scan that finds the next one; the final
// one follows the last scan in the same way, marked last. Reset sets vcount_q to 5 and clears
// visited marks and stack depth; the adjacency memory is undefined until rows are loaded.
module adjacency_matrix_dfs_order #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  amdfs_pkg::amdfs_item_t  item_i,
  output logic                    strobe_o,
  output amdfs_pkg::amdfs_result_t result_o,
  input  logic                    cfg_we_i,
  input  logic [4:0]              cfg_wdata_i
);
  import amdfs_pkg::*;

  localparam int unsigned AdjAw = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned StkAw = $clog2(ResultCap);
  localparam logic [6:0]  MaxV  = 7'(MAX_VERTICES);
  localparam logic [CntW-1:0] LimCap =
    CntW'((MAX_VERTICES < ResultCap) ? MAX_VERTICES : ResultCap);

  // lowest set bit of a row
  function automatic logic [VtxW-1:0] lowest_bit(input logic [RowW-1:0] v);
    logic [VtxW-1:0] r;
    r = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (v[i]) r = VtxW'(i);
    end
    return r;
  endfunction

  amdfs_state_e    state_q, state_d;
  logic [CntW-1:0] vcount_q;
  logic [RowW-1:0] visited_q, visited_d;
  logic [CntW-1:0] sp_q, sp_d;
  logic [VtxW-1:0] top_q, top_d;
  logic [VtxW-1:0] pend_q, pend_d;
  logic            strobe_q, strobe_d;
  amdfs_result_t   result_q, result_d;

  logic [RowW-1:0] adj_mem [MAX_VERTICES];
  logic [RowW-1:0] adj_rd_q;
  logic            adj_we;
  logic [AdjAw-1:0] adj_waddr, adj_raddr;
  logic [VtxW-1:0] adj_rvtx;

  // the stack keeps only vertices: every neighbour below a frame's resume point is
  // already visited, so rescanning with the visited mask finds the same next one
  logic [VtxW-1:0] stk_mem [ResultCap];
  logic [VtxW-1:0] stk_rd_q;
  logic            stk_we;
  logic [CntW-1:0] sp_dec;

  logic            accept;
  logic [CntW-1:0] lim;
  logic [RowW-1:0] lim_mask;
  logic [RowW-1:0] cand;
  logic            found;
  logic [VtxW-1:0] next_vtx;
  logic            start_bad;
  logic [6:0]      row_wide, rvtx_wide;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // scan limit and mask of vertices in use
  assign lim = (vcount_q > LimCap) ? LimCap : vcount_q;
  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      lim_mask[i] = (CntW'(i) < lim);
    end
  end

  assign start_bad = ({1'b0, item_i.start_vertex} >= lim);
  assign cand      = adj_rd_q & ~visited_q & lim_mask;
  assign found     = |cand;
  assign next_vtx  = lowest_bit(cand);
  assign sp_dec    = sp_q - CntW'(1);

  // adjacency memory addressing
  assign row_wide  = {3'b000, item_i.row_index};
  assign rvtx_wide = {3'b000, adj_rvtx};
  assign adj_waddr = row_wide[AdjAw-1:0];
  assign adj_raddr = rvtx_wide[AdjAw-1:0];
  assign adj_we    = accept && (item_i.kind == KindLoad) && (row_wide < MaxV);

  always_comb begin
    unique case (state_q)
      StIdle:  adj_rvtx = item_i.start_vertex;
      StScan:  adj_rvtx = next_vtx;
      StPop:   adj_rvtx = stk_rd_q;
      default: adj_rvtx = item_i.start_vertex;
    endcase
  end

  assign stk_we = (state_q == StScan) && found;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (item_i.kind == KindStart) && !start_bad) state_d = StScan;
      end
      StScan: begin
        if (!found) state_d = (sp_q == '0) ? StIdle : StPop;
      end
      StPop:   state_d = StScan;
      default: state_d = StIdle;
    endcase
  end

  // walk datapath and result generation
  always_comb begin
    visited_d = visited_q;
    sp_d      = sp_q;
    top_d     = top_q;
    pend_d    = pend_q;
    strobe_d  = 1'b0;
    result_d  = result_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (item_i.kind == KindStart)) begin
          if (start_bad) begin
            strobe_d           = 1'b1;
            result_d.vertex    = '0;
            result_d.last      = 1'b1;
            result_d.bad_start = 1'b1;
          end else begin
            visited_d = RowW'(1) << item_i.start_vertex;
            sp_d      = '0;
            top_d     = item_i.start_vertex;
            pend_d    = item_i.start_vertex;
          end
        end
      end
      StScan: begin
        // the held vertex goes out once the next one is known or the walk ends
        if (found) begin
          strobe_d           = 1'b1;
          result_d.vertex    = pend_q;
          result_d.last      = 1'b0;
          result_d.bad_start = 1'b0;
          visited_d          = visited_q | (RowW'(1) << next_vtx);
          sp_d               = sp_q + CntW'(1);
          top_d              = next_vtx;
          pend_d             = next_vtx;
        end else if (sp_q == '0) begin
          strobe_d           = 1'b1;
          result_d.vertex    = pend_q;
          result_d.last      = 1'b1;
          result_d.bad_start = 1'b0;
        end else begin
          sp_d = sp_dec;
        end
      end
      StPop: begin
        top_d = stk_rd_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vcount_q  <= CntW'(5);
      visited_q <= '0;
      sp_q      <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      sp_q      <= sp_d;
      strobe_q  <= strobe_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    pend_q   <= pend_d;
    result_q <= result_d;
  end

  // adjacency memory, registered read
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= item_i.row_bits;
    adj_rd_q <= adj_mem[adj_raddr];
  end

  // walk stack memory, push of the current vertex, registered read of the one below
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[sp_q[StkAw-1:0]] <= top_q;
    stk_rd_q <= stk_mem[sp_dec[StkAw-1:0]];
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // the stack is empty whenever no walk is running
  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (sp_q == '0))
    else $error("walk stack not empty while idle");

  // the vertex being scanned has always been marked visited
  a_top_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> visited_q[top_q])
    else $error("scanned vertex not marked visited");

  // a walk never ends without emitting its final result in the next cycle
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && state_d == StIdle) |=> (strobe_o && result_o.last))
    else $error("walk ended without a last result");

  // a bad start result is always a single final result
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.bad_start) |-> (result_o.last && $past(state_q) == StIdle))
    else $error("bad start result malformed");

endmodule
